// ===== rtl/core/rtcm3_frame_receiver_unit_defines.svh =====
// assertion macros shared by the frame receiver rtl
// expects clk and rst_n in the scope of each use
`ifndef RTCM3_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define RTCM3_FRAME_RECEIVER_UNIT_DEFINES_SVH

// condition holds at every edge out of reset
`define RFR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define RFR_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define RFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rtcm3fr_pkg.sv =====
// types and constants of the rtcm3 frame receiver
// no dependencies
`timescale 1ns / 1ps

package rtcm3fr_pkg;

  localparam logic [7:0]  PREAMBLE   = 8'hD3;
  localparam logic [23:0] CRC_POLY   = 24'h864CFB;
  localparam logic [11:0] MT_1002    = 12'd1002;
  localparam logic [11:0] MT_1004    = 12'd1004;
  localparam logic [11:0] MT_1019    = 12'd1019;
  // header bytes before the payload, crc bytes buffered before the last one
  localparam logic [10:0] HDR_BYTES  = 11'd3;
  localparam logic [10:0] CRC_HI_LEN = 11'd2;
  // last byte index of the longest frame
  localparam logic [10:0] MAX_COUNT  = 11'd1028;

  typedef enum logic [2:0] {
    ST_TAKEN        = 3'd0,
    ST_BAD_PREAMBLE = 3'd1,
    ST_CRC_ERR      = 3'd2,
    ST_GOOD_SUP     = 3'd3,
    ST_GOOD_UNSUP   = 3'd4
  } rfr_status_t;

  typedef struct packed {
    rfr_status_t status;
    logic [11:0] message_type;
    logic [9:0]  payload_length;
  } rfr_result_t;

endpackage

// ===== rtl/core/rtcm3fr_crc.sv =====
// one byte step of crc-24q, msb first, no reflection
// uses rtcm3fr_pkg for the polynomial
`timescale 1ns / 1ps

module rtcm3fr_crc
  import rtcm3fr_pkg::*;
(
  input  logic [23:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [23:0] crc_out
);

  always_comb begin
    logic [23:0] c;
    c = crc_in ^ {data_in, 16'h0000};
    for (int k = 0; k < 8; k++) begin
      if (c[23]) begin
        c = {c[22:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[22:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

// ===== rtl/core/rtcm3fr_parse.sv =====
// frame state and per-byte decode: header, crc, trailer compare
// uses rtcm3fr_pkg, rtcm3fr_crc and the assertion macro header
`timescale 1ns / 1ps
`include "rtcm3_frame_receiver_unit_defines.svh"

module rtcm3fr_parse
  import rtcm3fr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        advance,
  input  logic [7:0]  byte_in,
  output rfr_result_t res
);

  logic [10:0] cnt_r, cnt_nxt;
  logic [9:0]  len_r, len_nxt;
  logic [23:0] crc_r, crc_nxt;
  logic [15:0] rxh_r, rxh_nxt;
  logic [11:0] type_r, type_nxt;

  logic [9:0]  len_new;
  logic [11:0] type_new;
  logic [10:0] body;
  logic [23:0] crc_seed;
  logic [23:0] crc_stepped;
  logic [23:0] rx_full;

  assign crc_seed = (cnt_r == 11'd0) ? 24'h000000 : crc_r;
  assign rx_full  = {rxh_r, byte_in};

  rtcm3fr_crc u_crc (
    .crc_in  (crc_seed),
    .data_in (byte_in),
    .crc_out (crc_stepped)
  );

  always_comb begin
    len_new = len_r;
    if (cnt_r == 11'd1) begin
      len_new = {byte_in[1:0], 8'h00};
    end else if (cnt_r == 11'd2) begin
      len_new = {len_r[9:8], len_r[7:0] | byte_in};
    end
    type_new = type_r;
    if (cnt_r == 11'd3) begin
      type_new = {byte_in, 4'h0};
    end else if (cnt_r == 11'd4) begin
      type_new = {type_r[11:4], type_r[3:0] | byte_in[7:4]};
    end
    body = {1'b0, len_new} + HDR_BYTES;
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    len_nxt  = len_r;
    crc_nxt  = crc_r;
    rxh_nxt  = rxh_r;
    type_nxt = type_r;
    res.status         = ST_TAKEN;
    res.message_type   = 12'h000;
    res.payload_length = 10'h000;
    if (cnt_r == 11'd0) begin
      if (byte_in != PREAMBLE) begin
        res.status = ST_BAD_PREAMBLE;
      end else begin
        crc_nxt  = crc_stepped;
        rxh_nxt  = 16'h0000;
        type_nxt = 12'h000;
        len_nxt  = 10'h000;
        cnt_nxt  = 11'd1;
      end
    end else begin
      len_nxt  = len_new;
      type_nxt = type_new;
      if (cnt_r < body) begin
        crc_nxt = crc_stepped;
        cnt_nxt = cnt_r + 11'd1;
      end else if (cnt_r < body + CRC_HI_LEN) begin
        rxh_nxt = {rxh_r[7:0], byte_in};
        cnt_nxt = cnt_r + 11'd1;
      end else begin
        // last trailer byte closes the frame
        res.payload_length = len_new;
        if (rx_full != crc_r) begin
          res.status = ST_CRC_ERR;
        end else begin
          res.message_type = type_new;
          if (type_new == MT_1002 || type_new == MT_1004 || type_new == MT_1019) begin
            res.status = ST_GOOD_SUP;
          end else begin
            res.status = ST_GOOD_UNSUP;
          end
        end
        cnt_nxt = 11'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 11'd0;
    end else if (advance) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= 10'h000;
      crc_r  <= 24'h000000;
      rxh_r  <= 16'h0000;
      type_r <= 12'h000;
    end else if (advance) begin
      len_r  <= len_nxt;
      crc_r  <= crc_nxt;
      rxh_r  <= rxh_nxt;
      type_r <= type_nxt;
    end
  end

  `RFR_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= MAX_COUNT, "byte count past longest frame")
  `RFR_ASSERT_NEXT(a_end_idle, advance && res.status != ST_TAKEN, cnt_r == 11'd0,
    "frame not back to idle after a report")
  `RFR_ASSERT_NEXT(a_start, advance && cnt_r == 11'd0 && byte_in == PREAMBLE,
    cnt_r == 11'd1, "preamble did not start a frame")

endmodule

// ===== rtl/core/rtcm3_frame_receiver_unit.sv =====
// rtcm3 frame receiver: one byte beat in, one status beat out
// result valid in the cycle after the byte beat is taken
// throughput: one byte per cycle unless a waiting result is stalled, set by the single result register
// in_stall follows out_stall only while a result is waiting in that register
// synchronous active-low reset returns the receiver to preamble hunt, output empty
`timescale 1ns / 1ps
`include "rtcm3_frame_receiver_unit_defines.svh"

module rtcm3_frame_receiver_unit
  import rtcm3fr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [11:0] out_message_type,
  output logic [9:0]  out_payload_length
);

  logic        in_accept;
  logic        out_valid_r, out_valid_nxt;
  rfr_result_t res;
  rfr_result_t res_r;

  // take a beat whenever the result register is empty or draining
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  rtcm3fr_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (in_accept),
    .byte_in (in_byte_in),
    .res     (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = res_r.status;
  assign out_message_type   = res_r.message_type;
  assign out_payload_length = res_r.payload_length;

  `RFR_ASSERT_NEXT(a_accept_out, in_accept, out_valid_r, "accepted beat left no result")
  `RFR_ASSERT_IMPLY(a_sup_type, out_valid_r && res_r.status == ST_GOOD_SUP,
    res_r.message_type == MT_1002 || res_r.message_type == MT_1004 ||
    res_r.message_type == MT_1019, "supported status with other type")
  `RFR_ASSERT_IMPLY(a_idle_zero,
    out_valid_r && (res_r.status == ST_TAKEN || res_r.status == ST_BAD_PREAMBLE),
    res_r.message_type == 12'h000 && res_r.payload_length == 10'h000,
    "non-final beat carries frame fields")

endmodule
